/* src/bppm_pkg.sv */
package bppm_pkg;

  localparam int MASK_W  = 64;
  localparam int BYTE_W  = 8;
  localparam int PAIR_W  = 2 * BYTE_W;
  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_BYTE = 2'd1,
    OP_NIL  = 2'd2
  } op_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_QUERY_MASK   = 2'd0;
  localparam cfg_idx_t CFG_PAIRS_IN_USE = 2'd1;

  localparam logic [COUNT_W-1:0] PAIRS_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SLOT_W-1:0] slot;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic [BYTE_W-1:0] string_byte;
    logic              last_byte;
  } in_word_t;

  typedef struct packed {
    logic [MASK_W-1:0] imprint_mask;
    logic              passes_query;
  } out_word_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic               wr_en;
    logic [COUNT_W-1:0] wr_slot;
    logic [PAIR_W-1:0]  wr_pair;
    logic               cap;
    logic [PAIR_W-1:0]  key_a;
    logic               key_a_v;
    logic [PAIR_W-1:0]  key_b;
    logic               key_b_v;
    logic [COUNT_W-1:0] pairs_in_use;
  } bcast_t;

  // one bit per key being matched in the same word
  typedef struct packed {
    logic a;
    logic b;
  } claim_t;

endpackage

/* src/bppm_cell.sv */
module bppm_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bppm_pkg::bcast_t bc,
  input  bppm_pkg::claim_t claim_i,
  output bppm_pkg::claim_t claim_o,
  output bppm_pkg::claim_t set_o
);

  logic [bppm_pkg::PAIR_W-1:0] pair_r;
  logic                        valid_r;
  logic                        hit_a_r;
  logic                        hit_b_r;
  logic                        hit_a_nxt;
  logic                        hit_b_nxt;
  logic                        wr;
  logic                        in_use;

  assign wr     = bc.wr_en && (bc.wr_slot == bppm_pkg::COUNT_W'(IDX));
  assign in_use = bc.pairs_in_use > bppm_pkg::COUNT_W'(IDX);

  // header entry, no reset: read only once valid
  always_ff @(posedge clk) begin
    if (wr) begin
      pair_r <= bc.wr_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr) begin
      valid_r <= 1'b1;
    end
  end

  // compare against both broadcast keys
  always_comb begin
    hit_a_nxt = valid_r && in_use && bc.key_a_v && (pair_r == bc.key_a);
    hit_b_nxt = valid_r && in_use && bc.key_b_v && (pair_r == bc.key_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_a_r <= 1'b0;
      hit_b_r <= 1'b0;
    end else if (bc.cap) begin
      hit_a_r <= hit_a_nxt;
      hit_b_r <= hit_b_nxt;
    end
  end

  // lower cells claim first; pass the claim upward
  always_comb begin
    claim_o.a = claim_i.a | hit_a_r;
    claim_o.b = claim_i.b | hit_b_r;
    set_o.a   = hit_a_r & ~claim_i.a;
    set_o.b   = hit_b_r & ~claim_i.b;
  end

endmodule

/* src/byte_pair_presence_mask.sv */
// A word ending a string is accepted into the match stage, where the cells compare
//   and register hits; the lowest-hit chain and mask merge then load the output
//   register when the match stage retires, which the output stall can hold back.
// Throughput: one input word per cycle; the input stalls only while the output
//   register is full and stalled and the match stage holds a result for it.
// Reset (rst_n, synchronous, active low) clears entry valid bits, string state,
//   the running mask, the output valid, query_mask to 0 and pairs_in_use to 64.
module byte_pair_presence_mask #(
  parameter int HEADER_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bppm_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bppm_pkg::out_word_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  bppm_pkg::cfg_idx_t                  cfg_index,
  input  logic [bppm_pkg::MASK_W-1:0]         cfg_data
);

  localparam int MASK_CELLS = (HEADER_ENTRIES < bppm_pkg::MASK_W) ?
                              HEADER_ENTRIES : bppm_pkg::MASK_W;

  logic [bppm_pkg::MASK_W-1:0]  query_mask_r;
  logic [bppm_pkg::COUNT_W-1:0] pairs_in_use_r;
  logic [bppm_pkg::BYTE_W-1:0]  prev_byte_r, prev_byte_nxt;
  logic                         inside_r, inside_nxt;
  logic [bppm_pkg::MASK_W-1:0]  running_r;
  logic                         s1_valid_r, s1_valid_nxt;
  logic                         s1_emit_r, s1_emit_nxt;
  logic                         s1_nil_r, s1_nil_nxt;
  logic                         out_valid_r;
  bppm_pkg::out_word_t          out_data_r;

  logic                         acc;
  logic                         is_load, is_byte, is_nil;
  logic                         s1_go;
  bppm_pkg::bcast_t             bc;
  bppm_pkg::claim_t             chain [HEADER_ENTRIES];
  bppm_pkg::claim_t             set_all [HEADER_ENTRIES];
  logic [HEADER_ENTRIES-1:0]    set_a_vec;
  logic [HEADER_ENTRIES-1:0]    set_b_vec;
  logic [bppm_pkg::MASK_W-1:0]  set_vec;
  logic [bppm_pkg::MASK_W-1:0]  mask_new;

  // handshake
  assign s1_go     = s1_valid_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign acc       = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_mask_r   <= '0;
      pairs_in_use_r <= bppm_pkg::PAIRS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bppm_pkg::CFG_QUERY_MASK:   query_mask_r   <= cfg_data;
        bppm_pkg::CFG_PAIRS_IN_USE: pairs_in_use_r <= cfg_data[bppm_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // opcode decode
  always_comb begin
    is_load = 1'b0;
    is_byte = 1'b0;
    is_nil  = 1'b0;
    unique case (in_data.opcode)
      bppm_pkg::OP_LOAD: is_load = 1'b1;
      bppm_pkg::OP_BYTE: is_byte = 1'b1;
      bppm_pkg::OP_NIL:  is_nil  = 1'b1;
      default: ;
    endcase
  end

  // broadcast to the cells: load port and the two pairs this word forms
  always_comb begin
    bc.wr_en        = acc && is_load;
    bc.wr_slot      = {1'b0, in_data.slot};
    bc.wr_pair      = {in_data.second_byte, in_data.first_byte};
    bc.cap          = acc;
    bc.key_a        = {in_data.string_byte, prev_byte_r};
    bc.key_a_v      = is_byte && inside_r;
    bc.key_b        = {8'h00, in_data.string_byte};
    bc.key_b_v      = is_byte && in_data.last_byte && (in_data.string_byte != 8'h00);
    bc.pairs_in_use = pairs_in_use_r;
  end

  // string state and match stage control
  always_comb begin
    prev_byte_nxt = prev_byte_r;
    inside_nxt    = inside_r;
    s1_valid_nxt  = s1_valid_r && !s1_go;
    s1_emit_nxt   = s1_emit_r;
    s1_nil_nxt    = s1_nil_r;
    if (acc) begin
      s1_valid_nxt = is_byte || is_nil;
      s1_nil_nxt   = is_nil;
      s1_emit_nxt  = is_nil || (is_byte &&
                     ((in_data.string_byte == 8'h00) || in_data.last_byte));
      if (is_nil) begin
        prev_byte_nxt = '0;
        inside_nxt    = 1'b0;
      end else if (is_byte) begin
        if ((in_data.string_byte == 8'h00) || in_data.last_byte) begin
          prev_byte_nxt = '0;
          inside_nxt    = 1'b0;
        end else begin
          prev_byte_nxt = in_data.string_byte;
          inside_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_byte_r <= '0;
      inside_r    <= 1'b0;
      s1_valid_r  <= 1'b0;
      s1_emit_r   <= 1'b0;
      s1_nil_r    <= 1'b0;
    end else begin
      prev_byte_r <= prev_byte_nxt;
      inside_r    <= inside_nxt;
      s1_valid_r  <= s1_valid_nxt;
      s1_emit_r   <= s1_emit_nxt;
      s1_nil_r    <= s1_nil_nxt;
    end
  end

  // row of header cells, claim chained from index 0 upward
  assign chain[0] = '0;

  for (genvar i = 0; i < HEADER_ENTRIES; i++) begin : g_cell
    if (i + 1 < HEADER_ENTRIES) begin : g_mid
      bppm_cell #(.IDX(i)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .bc      (bc),
        .claim_i (chain[i]),
        .claim_o (chain[i+1]),
        .set_o   (set_all[i])
      );
    end else begin : g_end
      bppm_cell #(.IDX(i)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .bc      (bc),
        .claim_i (chain[i]),
        .claim_o (),
        .set_o   (set_all[i])
      );
    end
    assign set_a_vec[i] = set_all[i].a;
    assign set_b_vec[i] = set_all[i].b;
  end

  // only the low 64 entries own a mask bit
  always_comb begin
    set_vec = '0;
    for (int i = 0; i < MASK_CELLS; i++) begin
      set_vec[i] = set_a_vec[i] | set_b_vec[i];
    end
  end

  assign mask_new = s1_nil_r ? '0 : (running_r | set_vec);

  // running mask and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
    end else if (s1_go) begin
      running_r <= s1_emit_r ? '0 : mask_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit_r) begin
      out_data_r.imprint_mask <= mask_new;
      out_data_r.passes_query <= ((mask_new & query_mask_r) == query_mask_r);
    end
  end

  // each pair sets at most one entry
  a_one_hit_a: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(set_a_vec) <= 1)
    else $error("more than one entry claimed for first pair");

  a_one_hit_b: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(set_b_vec) <= 1)
    else $error("more than one entry claimed for final pair");

  // mask starts clean after each string result
  a_mask_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_emit_r) |=> (running_r == '0))
    else $error("running mask not cleared after result");

  // a result appears only from a retiring string end
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_go && s1_emit_r))
    else $error("output valid without a finished string");

  // open string always remembers a nonzero byte
  a_inside_prev: assert property (@(posedge clk) disable iff (!rst_n)
    inside_r == (prev_byte_r != 8'h00))
    else $error("string state and previous byte disagree");

endmodule
